### design/jbec_pkg.sv
// ----------------------------------------------------------------------------
// jbec_pkg
// Types, Huffman code tables and constants of the JPEG block entropy coder.
// ----------------------------------------------------------------------------
package jbec_pkg;

  typedef logic [20:0] code_entry_t;           // code in 20..5, length in 4..0
  typedef code_entry_t ac_rom_t [256];
  typedef code_entry_t dc_rom_t [12];
  typedef logic [7:0]  count_list_t [16];
  typedef logic [7:0]  sym_list_t [162];

  // Bit packet handed from the encoder to the packer, left aligned
  typedef struct packed {
    logic        flush;
    logic [63:0] bits;
    logic [6:0]  len;
  } pkt_t;

  localparam logic [7:0] ZRL_SYM   = 8'hF0;
  localparam logic [7:0] EOB_SYM   = 8'h00;
  localparam logic [7:0] STUFF_TAG = 8'hFF;
  localparam logic [7:0] STUFF_BYTE = 8'h00;
  localparam logic [5:0] LAST_INDEX = 6'd63;
  localparam logic [3:0] RUN_MAX = 4'd15;

  localparam count_list_t DCL_BITS = '{0,1,5,1,1,1,1,1,1,0,0,0,0,0,0,0};
  localparam count_list_t DCC_BITS = '{0,3,1,1,1,1,1,1,1,1,1,0,0,0,0,0};
  localparam count_list_t ACL_BITS = '{0,2,1,3,3,2,4,3,5,5,4,4,0,0,1,8'h7d};
  localparam count_list_t ACC_BITS = '{0,2,1,2,4,4,3,4,7,5,4,4,0,1,2,8'h77};

  localparam sym_list_t ACL_VALS = '{
    8'h01,8'h02,8'h03,8'h00,8'h04,8'h11,8'h05,8'h12,8'h21,8'h31,8'h41,8'h06,8'h13,8'h51,
    8'h61,8'h07,8'h22,8'h71,8'h14,8'h32,8'h81,8'h91,8'ha1,8'h08,8'h23,8'h42,8'hb1,8'hc1,
    8'h15,8'h52,8'hd1,8'hf0,8'h24,8'h33,8'h62,8'h72,8'h82,8'h09,8'h0a,8'h16,8'h17,8'h18,
    8'h19,8'h1a,8'h25,8'h26,8'h27,8'h28,8'h29,8'h2a,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,
    8'h3a,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4a,8'h53,8'h54,8'h55,8'h56,8'h57,
    8'h58,8'h59,8'h5a,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6a,8'h73,8'h74,8'h75,
    8'h76,8'h77,8'h78,8'h79,8'h7a,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h8a,8'h92,
    8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,8'ha2,8'ha3,8'ha4,8'ha5,8'ha6,8'ha7,
    8'ha8,8'ha9,8'haa,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,8'hc2,8'hc3,
    8'hc4,8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,8'hca,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,8'hd8,
    8'hd9,8'hda,8'he1,8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hf1,8'hf2,
    8'hf3,8'hf4,8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'hfa};

  localparam sym_list_t ACC_VALS = '{
    8'h00,8'h01,8'h02,8'h03,8'h11,8'h04,8'h05,8'h21,8'h31,8'h06,8'h12,8'h41,8'h51,8'h07,
    8'h61,8'h71,8'h13,8'h22,8'h32,8'h81,8'h08,8'h14,8'h42,8'h91,8'ha1,8'hb1,8'hc1,8'h09,
    8'h23,8'h33,8'h52,8'hf0,8'h15,8'h62,8'h72,8'hd1,8'h0a,8'h16,8'h24,8'h34,8'he1,8'h25,
    8'hf1,8'h17,8'h18,8'h19,8'h1a,8'h26,8'h27,8'h28,8'h29,8'h2a,8'h35,8'h36,8'h37,8'h38,
    8'h39,8'h3a,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4a,8'h53,8'h54,8'h55,8'h56,
    8'h57,8'h58,8'h59,8'h5a,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6a,8'h73,8'h74,
    8'h75,8'h76,8'h77,8'h78,8'h79,8'h7a,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,
    8'h8a,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,8'ha2,8'ha3,8'ha4,8'ha5,
    8'ha6,8'ha7,8'ha8,8'ha9,8'haa,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,
    8'hc2,8'hc3,8'hc4,8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,8'hca,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,
    8'hd7,8'hd8,8'hd9,8'hda,8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hf2,
    8'hf3,8'hf4,8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'hfa};

  // Canonical Huffman codes from the code-length counts
  function automatic ac_rom_t build_ac(input count_list_t bits, input sym_list_t vals);
    ac_rom_t rom;
    int c;
    int k;
    rom = '{default: '0};
    c = 0;
    k = 0;
    for (int len = 1; len <= 16; len++) begin
      for (int i = 0; i < int'(bits[len-1]); i++) begin
        rom[vals[k]] = {16'(c), 5'(len)};
        c++;
        k++;
      end
      c = c << 1;
    end
    return rom;
  endfunction

  function automatic dc_rom_t build_dc(input count_list_t bits);
    dc_rom_t rom;
    int c;
    int k;
    rom = '{default: '0};
    c = 0;
    k = 0;
    for (int len = 1; len <= 16; len++) begin
      for (int i = 0; i < int'(bits[len-1]); i++) begin
        if (k < 12) rom[k] = {16'(c), 5'(len)};
        c++;
        k++;
      end
      c = c << 1;
    end
    return rom;
  endfunction

  localparam ac_rom_t AC_LUMA   = build_ac(ACL_BITS, ACL_VALS);
  localparam ac_rom_t AC_CHROMA = build_ac(ACC_BITS, ACC_VALS);
  localparam dc_rom_t DC_LUMA   = build_dc(DCL_BITS);
  localparam dc_rom_t DC_CHROMA = build_dc(DCC_BITS);

  // Three ZRL codes back to back, left aligned (luma 11 bits, chroma 10 bits)
  localparam logic [4:0]  ZRL_LEN_LUMA   = AC_LUMA[ZRL_SYM][4:0];
  localparam logic [4:0]  ZRL_LEN_CHROMA = AC_CHROMA[ZRL_SYM][4:0];
  localparam logic [63:0] ZRL_REP_LUMA   = {{3{AC_LUMA[ZRL_SYM][15:5]}}, 31'b0};
  localparam logic [63:0] ZRL_REP_CHROMA = {{3{AC_CHROMA[ZRL_SYM][14:5]}}, 34'b0};

endpackage

### design/jbec_if.sv
// ----------------------------------------------------------------------------
// jbec_if
// Valid/ready channels of the coder: coefficient items in, stream bytes out.
// ----------------------------------------------------------------------------
interface jbec_in_if;
  logic              valid;
  logic              ready;
  logic              op;
  logic signed [11:0] coefficient;
  logic [1:0]        component;
  modport source (output valid, op, coefficient, component, input ready);
  modport sink   (input valid, op, coefficient, component, output ready);
endinterface

interface jbec_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;
  modport source (output valid, out_byte, last_byte, input ready);
  modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

### design/jbec_encoder.sv
// ----------------------------------------------------------------------------
// jbec_encoder
// Input register, DC prediction, run tracking and Huffman lookup; builds one
// left-aligned bit packet per item.
// ----------------------------------------------------------------------------
module jbec_encoder (
  input  logic           clk,
  input  logic           rst,
  jbec_in_if.sink        in_ch,
  output logic           pkt_valid,
  output jbec_pkg::pkt_t pkt,
  input  logic           pkt_ready
);

  logic               in_valid_r;
  logic               op_r;
  logic signed [11:0] coef_r;
  logic [1:0]         comp_r;

  logic [5:0]         coef_index;
  logic [5:0]         zero_run;
  logic signed [11:0] dc_predictor [3];

  logic               advance;
  logic               move;
  logic [1:0]         comp_eff;
  logic               chroma;
  logic signed [12:0] diff;
  logic signed [11:0] dsat;
  logic signed [11:0] asat;
  logic signed [11:0] val;
  logic [10:0]        mag;
  logic [3:0]         sz;
  logic [3:0]         sv;
  logic               use_val;
  logic [1:0]         nz;
  jbec_pkg::code_entry_t entry;
  logic [11:0]        vb;
  logic [11:0]        vbm;
  logic [26:0]        cv;
  logic [5:0]         cvl;
  logic [63:0]        cv_left;
  logic [6:0]         zl;
  logic [63:0]        zrep;
  jbec_pkg::pkt_t     pkt_next;

  function automatic logic [3:0] size_of(input logic [10:0] a);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 11; i++) begin
      if (a[i]) n = 4'(i + 1);
    end
    return n;
  endfunction

  assign advance      = !pkt_valid || pkt_ready;
  assign move         = in_valid_r && advance;
  assign in_ch.ready  = !in_valid_r || advance;

  always_comb begin
    comp_eff = (comp_r == 2'd3) ? 2'd2 : comp_r;
    chroma   = comp_eff != 2'd0;
    diff     = {coef_r[11], coef_r} - {dc_predictor[comp_eff][11], dc_predictor[comp_eff]};
    if (diff > 13'sd2047)       dsat = 12'sd2047;
    else if (diff < -13'sd2047) dsat = -12'sd2047;
    else                        dsat = diff[11:0];
    if (coef_r > 12'sd1023)       asat = 12'sd1023;
    else if (coef_r < -12'sd1023) asat = -12'sd1023;
    else                          asat = coef_r;
    val = (coef_index == 6'd0) ? dsat : asat;
    mag = val[11] ? 11'(-val) : val[10:0];
    sz  = size_of(mag);

    entry   = '0;
    use_val = 1'b0;
    nz      = 2'd0;
    if (coef_index == 6'd0) begin
      entry   = chroma ? jbec_pkg::DC_CHROMA[sz] : jbec_pkg::DC_LUMA[sz];
      use_val = 1'b1;
    end else if (asat == 12'sd0) begin
      if (coef_index == jbec_pkg::LAST_INDEX)
        entry = chroma ? jbec_pkg::AC_CHROMA[jbec_pkg::EOB_SYM]
                       : jbec_pkg::AC_LUMA[jbec_pkg::EOB_SYM];
    end else begin
      entry   = chroma ? jbec_pkg::AC_CHROMA[{zero_run[3:0], sz}]
                       : jbec_pkg::AC_LUMA[{zero_run[3:0], sz}];
      use_val = 1'b1;
      nz      = zero_run[5:4];
    end

    sv      = use_val ? sz : 4'd0;
    vb      = val[11] ? 12'(val - 12'sd1) : val;
    vbm     = vb & ((12'd1 << sv) - 12'd1);
    cv      = ({11'b0, entry[20:5]} << sv) | {15'b0, vbm};
    cvl     = {1'b0, entry[4:0]} + {2'b0, sv};
    cv_left = {cv, 37'b0} << (6'd27 - cvl);

    // ZRL prefix: the top nz codes of the repeated pattern
    zl   = 7'(nz) * (chroma ? {2'b0, jbec_pkg::ZRL_LEN_CHROMA} : {2'b0, jbec_pkg::ZRL_LEN_LUMA});
    zrep = chroma ? jbec_pkg::ZRL_REP_CHROMA : jbec_pkg::ZRL_REP_LUMA;

    pkt_next.flush = op_r;
    if (op_r || (coef_index != 6'd0 && asat == 12'sd0 &&
                 coef_index != jbec_pkg::LAST_INDEX)) begin
      pkt_next.bits = '0;
      pkt_next.len  = '0;
    end else begin
      pkt_next.bits = (zrep & ~({64{1'b1}} >> zl)) | (cv_left >> zl);
      pkt_next.len  = zl + {1'b0, cvl};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_r <= 1'b0;
      pkt_valid  <= 1'b0;
      coef_index <= '0;
      zero_run   <= '0;
      for (int i = 0; i < 3; i++) dc_predictor[i] <= '0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
        if (in_ch.valid) begin
          op_r   <= in_ch.op;
          coef_r <= in_ch.coefficient;
          comp_r <= in_ch.component;
        end
      end
      if (advance) pkt_valid <= in_valid_r;
      if (move) begin
        pkt <= pkt_next;
        if (op_r) begin
          coef_index <= '0;
          zero_run   <= '0;
          for (int i = 0; i < 3; i++) dc_predictor[i] <= '0;
        end else if (coef_index == 6'd0) begin
          dc_predictor[comp_eff] <= coef_r;
          zero_run   <= '0;
          coef_index <= 6'd1;
        end else begin
          if (asat != 12'sd0 || coef_index == jbec_pkg::LAST_INDEX) zero_run <= '0;
          else                                                     zero_run <= zero_run + 6'd1;
          coef_index <= coef_index + 6'd1;
        end
      end
    end
  end

endmodule

### design/jbec_packer.sv
// ----------------------------------------------------------------------------
// jbec_packer
// Bit accumulator and byte emitter with 0xFF stuffing and flush padding.
// ----------------------------------------------------------------------------
module jbec_packer (
  input  logic           clk,
  input  logic           rst,
  input  logic           pkt_valid,
  input  jbec_pkg::pkt_t pkt,
  output logic           pkt_ready,
  jbec_out_if.source     out_ch
);

  logic [71:0] acc;      // pending bits, left aligned, zero below cnt
  logic [6:0]  cnt;
  logic        stuff;
  logic        can_emit;
  logic [71:0] pad;

  assign can_emit  = !out_ch.valid || out_ch.ready;
  assign pkt_ready = !stuff && (cnt < 7'd8);
  assign pad       = ({8'hFF, 64'b0} >> cnt) & {8'hFF, 64'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
      acc          <= '0;
      cnt          <= '0;
      stuff        <= 1'b0;
    end else begin
      if (can_emit) begin
        if (stuff) begin
          out_ch.valid     <= 1'b1;
          out_ch.out_byte  <= jbec_pkg::STUFF_BYTE;
          out_ch.last_byte <= cnt < 7'd8;
          stuff            <= 1'b0;
        end else if (cnt >= 7'd8) begin
          out_ch.valid     <= 1'b1;
          out_ch.out_byte  <= acc[71:64];
          out_ch.last_byte <= (acc[71:64] != jbec_pkg::STUFF_TAG) && (cnt < 7'd16);
          stuff            <= acc[71:64] == jbec_pkg::STUFF_TAG;
          acc              <= acc << 8;
          cnt              <= cnt - 7'd8;
        end else begin
          out_ch.valid <= 1'b0;
        end
      end
      // merge only when drained below a byte, so never alongside an emit
      if (pkt_valid && pkt_ready) begin
        if (pkt.flush) begin
          if (cnt != 7'd0) begin
            acc <= acc | pad;
            cnt <= 7'd8;
          end
        end else begin
          acc <= acc | ({pkt.bits, 8'b0} >> cnt);
          cnt <= cnt + pkt.len;
        end
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= 7'd72)
    else $error("bit count overflow");
  a_ff_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.out_byte == jbec_pkg::STUFF_TAG) |-> !out_ch.last_byte)
    else $error("0xFF marked last before its stuffed byte");
  a_stuff_follows: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && out_ch.out_byte == jbec_pkg::STUFF_TAG)
      |=> (out_ch.valid && out_ch.out_byte == jbec_pkg::STUFF_BYTE))
    else $error("stuffed zero missing after 0xFF");

endmodule

### design/jpeg_block_entropy_coder_top.sv
// ----------------------------------------------------------------------------
// jpeg_block_entropy_coder_top
// Baseline JPEG Huffman entropy coder: coefficients in, stuffed bytes out.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  takes one item per handshake: op 0 with a quantized coefficient
//          in zigzag order (64 per block) and its component, or op 1 to
//          flush (pad to a byte with ones, clear predictors and position).
//   out_ch gives the coded stream one byte per handshake, 0x00 stuffed after
//          every 0xFF; last_byte marks the final byte caused by an item.
// Throughput: the encoder stage takes an item every cycle unless the packer
//   holds it back; the packer merges each item's bits and then emits the bytes
//   they cause, and takes no new item until fewer than eight bits are pending.
// Reset (rst, synchronous) empties the pipeline, clears the bit buffer, the
//   block position, the held zero run and the DC predictors.
// When the receiver stalls, the output byte holds, the packer stops emitting and
//   in_ch.ready drops once the input and packet registers are both full.
// ----------------------------------------------------------------------------
module jpeg_block_entropy_coder_top (
  input  logic       clk,
  input  logic       rst,
  jbec_in_if.sink    in_ch,
  jbec_out_if.source out_ch
);

  logic           pkt_valid;
  logic           pkt_ready;
  jbec_pkg::pkt_t pkt;

  jbec_encoder u_encoder (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .pkt_valid (pkt_valid),
    .pkt       (pkt),
    .pkt_ready (pkt_ready)
  );

  jbec_packer u_packer (
    .clk       (clk),
    .rst       (rst),
    .pkt_valid (pkt_valid),
    .pkt       (pkt),
    .pkt_ready (pkt_ready),
    .out_ch    (out_ch)
  );

endmodule

### bench/tb_jbec_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_jbec_chan_if
// Bench-side note: the coder's own channel interfaces (jbec_in_if and
// jbec_out_if) are used as they are; this file holds a small bench helper.
// ----------------------------------------------------------------------------
package tb_jbec_bench_pkg;

  // One coefficient or flush item as the bench queues it
  typedef struct packed {
    logic               op;
    logic signed [11:0] coefficient;
    logic [1:0]         component;
  } coef_item_t;

  // One expected stream byte
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } stream_byte_t;

  localparam logic OP_COEF  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [1:0] COMP_Y   = 2'd0;
  localparam logic [1:0] COMP_CB  = 2'd1;
  localparam logic [1:0] COMP_CR  = 2'd2;
  localparam logic [1:0] COMP_BAD = 2'd3;

endpackage

### bench/tb_jpeg_block_entropy_coder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_jpeg_block_entropy_coder_top
// Drives coefficient and flush items into the entropy coder, predicts the
// coded byte stream with a bench-side Huffman encoder and checks every byte.
// ----------------------------------------------------------------------------
module tb_jpeg_block_entropy_coder_top;
  import jbec_pkg::*;
  import tb_jbec_bench_pkg::*;

  logic clk;
  logic rst;

  jbec_in_if  in_ch ();
  jbec_out_if out_ch ();

  jpeg_block_entropy_coder_top dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // Code tables, built locally from the standard code-length lists
  code_entry_t luma_ac [256];
  code_entry_t chroma_ac [256];
  code_entry_t luma_dc [12];
  code_entry_t chroma_dc [12];

  // Encoder state mirror
  logic [6:0]         pend_bits;
  int unsigned        pend_count;
  int unsigned        blk_pos;
  int unsigned        held_zeros;
  logic signed [11:0] last_dc [3];

  coef_item_t   pending_items [$];
  stream_byte_t expected_bytes [$];
  stream_byte_t step_bytes [$];

  int  mismatches;
  int  cycle_count;
  bit  hold_sender;
  int  long_stall;
  int  burst_left;
  int  gap_left;
  int  queued_total;
  bit  paused_once;

  task automatic fill_table(input count_list_t counts, input sym_list_t syms,
                            input bit is_ac, input bit chroma);
    int c;
    int k;
    c = 0;
    k = 0;
    for (int len = 1; len <= 16; len++) begin
      for (int i = 0; i < int'(counts[len-1]); i++) begin
        if (is_ac) begin
          if (chroma) chroma_ac[syms[k]] = {16'(c), 5'(len)};
          else luma_ac[syms[k]] = {16'(c), 5'(len)};
        end else if (k < 12) begin
          if (chroma) chroma_dc[k] = {16'(c), 5'(len)};
          else luma_dc[k] = {16'(c), 5'(len)};
        end
        c++;
        k++;
      end
      c = c << 1;
    end
  endtask

  task automatic push_bits(input logic [15:0] code, input int unsigned len);
    logic [31:0] acc;
    logic [7:0]  b;
    if (len == 0) return;
    acc = ({25'b0, pend_bits} << len) | (32'(code) & ((32'd1 << len) - 1));
    pend_count += len;
    while (pend_count >= 8) begin
      b = 8'(acc >> (pend_count - 8));
      step_bytes.push_back('{out_byte: b, last_byte: 1'b0});
      if (b == STUFF_TAG) step_bytes.push_back('{out_byte: STUFF_BYTE, last_byte: 1'b0});
      pend_count -= 8;
    end
    pend_bits = 7'(acc & ((32'd1 << pend_count) - 1));
  endtask

  function automatic int unsigned magnitude_size(input int v);
    int unsigned a;
    int unsigned n;
    a = (v < 0) ? -v : v;
    n = 0;
    while (a != 0) begin
      a >>= 1;
      n++;
    end
    return n;
  endfunction

  task automatic push_entry(input code_entry_t e);
    push_bits(e[20:5], e[4:0]);
  endtask

  task automatic push_value(input int v, input int unsigned sz);
    push_bits(16'((v < 0) ? v - 1 : v), sz);
  endtask

  // Encode one accepted item and queue the bytes it should produce
  task automatic encode_item(input coef_item_t it);
    int          v;
    int          d;
    int unsigned comp;
    int unsigned sz;
    bit          chroma;
    code_entry_t sym;
    step_bytes.delete();
    v = int'(it.coefficient);
    comp = (it.component == COMP_BAD) ? 2 : int'(it.component);
    chroma = (comp != 0);
    if (it.op == OP_FLUSH) begin
      if (pend_count != 0) push_bits(16'((1 << (8 - pend_count)) - 1), 8 - pend_count);
      foreach (last_dc[i]) last_dc[i] = '0;
      blk_pos = 0;
      held_zeros = 0;
    end else if (blk_pos == 0) begin
      d = v - int'(last_dc[comp]);
      if (d > 2047) d = 2047;
      if (d < -2047) d = -2047;
      last_dc[comp] = it.coefficient;
      sz = magnitude_size(d);
      push_entry(chroma ? chroma_dc[sz] : luma_dc[sz]);
      push_value(d, sz);
      held_zeros = 0;
      blk_pos = 1;
    end else begin
      if (v > 1023) v = 1023;
      if (v < -1023) v = -1023;
      if (v == 0) begin
        if (blk_pos == LAST_INDEX) begin
          push_entry(chroma ? chroma_ac[EOB_SYM] : luma_ac[EOB_SYM]);
          held_zeros = 0;
        end else begin
          held_zeros = (held_zeros + 1) & 6'h3f;
        end
      end else begin
        sz = magnitude_size(v);
        while (held_zeros > RUN_MAX) begin
          push_entry(chroma ? chroma_ac[ZRL_SYM] : luma_ac[ZRL_SYM]);
          held_zeros -= 16;
        end
        sym = chroma ? chroma_ac[8'((held_zeros << 4) | sz)] : luma_ac[8'((held_zeros << 4) | sz)];
        push_entry(sym);
        push_value(v, sz);
        held_zeros = 0;
      end
      blk_pos = (blk_pos + 1) & 6'h3f;
    end
    if (step_bytes.size() > 0) step_bytes[step_bytes.size()-1].last_byte = 1'b1;
    foreach (step_bytes[i]) expected_bytes.push_back(step_bytes[i]);
  endtask

  function automatic coef_item_t make_item(input logic op, input int v, input logic [1:0] comp);
    coef_item_t it;
    it.op = op;
    it.coefficient = 12'(v);
    it.component = comp;
    return it;
  endfunction

  function automatic int rand_coef();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 75) return $urandom_range(0, 14) - 7;
    if (r < 90) return $urandom_range(0, 256) - 128;
    if (r < 97) return $urandom_range(0, 2048) - 1024;
    return $urandom_range(0, 4095) - 2048;
  endfunction

  task automatic queue_block(input logic [1:0] comp, input int unsigned n);
    int tail;
    tail = $urandom_range(0, 3);
    for (int i = 0; i < int'(n); i++) begin
      if (i == 0) pending_items.push_back(make_item(OP_COEF, rand_coef(), comp));
      else if (i >= 64 - tail * 12) pending_items.push_back(make_item(OP_COEF, 0, comp));
      else pending_items.push_back(make_item(OP_COEF, rand_coef(), comp));
    end
    queued_total += int'(n);
  endtask

  // Driver: bursts with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        encode_item('{op: in_ch.op, coefficient: in_ch.coefficient,
                      component: in_ch.component});
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (hold_sender || pending_items.size() == 0) begin
          in_ch.valid <= 1'b0;
        end else if (gap_left > 0) begin
          in_ch.valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else begin
          coef_item_t it;
          it = pending_items.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.op <= it.op;
          in_ch.coefficient <= it.coefficient;
          in_ch.component <= it.component;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Receiver with its own stall pattern and a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (long_stall > 0) begin
      out_ch.ready <= 1'b0;
      long_stall <= long_stall - 1;
    end else begin
      out_ch.ready <= (cycle_count % 300 < 80) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // Monitor
  always @(posedge clk) begin
    stream_byte_t exp_b;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected byte %02h last %0b", out_ch.out_byte, out_ch.last_byte);
      end else begin
        exp_b = expected_bytes.pop_front();
        if (exp_b.out_byte !== out_ch.out_byte || exp_b.last_byte !== out_ch.last_byte) begin
          mismatches++;
          if (mismatches <= 10)
            $display("byte mismatch: expected %02h last %0b, got %02h last %0b",
                     exp_b.out_byte, exp_b.last_byte, out_ch.out_byte, out_ch.last_byte);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("tb_jpeg_block_entropy_coder_top: done, errors");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = OP_COEF;
    in_ch.coefficient = '0;
    in_ch.component = COMP_Y;
    out_ch.ready = 1'b0;
    mismatches = 0;
    cycle_count = 0;
    hold_sender = 1'b0;
    long_stall = 0;
    burst_left = 0;
    gap_left = 0;
    queued_total = 0;
    paused_once = 1'b0;
    pend_bits = '0;
    pend_count = 0;
    blk_pos = 0;
    held_zeros = 0;
    foreach (last_dc[i]) last_dc[i] = '0;
    foreach (luma_ac[i]) begin
      luma_ac[i] = '0;
      chroma_ac[i] = '0;
    end
    fill_table(ACL_BITS, ACL_VALS, 1'b1, 1'b0);
    fill_table(ACC_BITS, ACC_VALS, 1'b1, 1'b1);
    fill_table(DCL_BITS, ACL_VALS, 1'b0, 1'b0);
    fill_table(DCC_BITS, ACC_VALS, 1'b0, 1'b1);
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: a DC extreme, saturated AC, long runs with ZRL, an index-63 EOB
    pending_items.push_back(make_item(OP_FLUSH, 0, COMP_Y));
    pending_items.push_back(make_item(OP_COEF, -2048, COMP_Y));
    pending_items.push_back(make_item(OP_COEF, 2047, COMP_Y));
    pending_items.push_back(make_item(OP_COEF, -1024, COMP_CB));
    for (int i = 0; i < 20; i++) pending_items.push_back(make_item(OP_COEF, 0, COMP_CR));
    pending_items.push_back(make_item(OP_COEF, 1024, COMP_BAD));
    for (int i = 0; i < 37; i++) pending_items.push_back(make_item(OP_COEF, 0, COMP_Y));
    pending_items.push_back(make_item(OP_COEF, -1, COMP_CB));
    pending_items.push_back(make_item(OP_COEF, 2047, COMP_BAD));
    pending_items.push_back(make_item(OP_FLUSH, 0, COMP_CR));
    pending_items.push_back(make_item(OP_COEF, 1, COMP_Y));
    for (int i = 1; i < 63; i++) pending_items.push_back(make_item(OP_COEF, 0, COMP_Y));
    pending_items.push_back(make_item(OP_COEF, 0, COMP_Y));
    pending_items.push_back(make_item(OP_FLUSH, 0, COMP_Y));

    // Long receiver hold-off while the sender keeps offering
    queue_block(COMP_Y, 64);
    long_stall = 200;
    wait (pending_items.size() == 0 && expected_bytes.size() == 0);
    repeat (10) @(posedge clk);

    // Random blocks, mostly well formed, some cut short by a flush
    queued_total = 0;
    while (queued_total < 286) begin
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) queue_block(2'($urandom_range(0, 3)), 64);
      else queue_block(2'($urandom_range(0, 3)), $urandom_range(1, 63));
      if ($urandom_range(0, 2) == 0 || r >= 7) begin
        pending_items.push_back(make_item(OP_FLUSH, $urandom_range(0, 4095) - 2048,
                                          2'($urandom_range(0, 3))));
        queued_total++;
      end
      if (queued_total > 140 && !paused_once) begin
        // Pause the sender until everything so far has drained
        paused_once = 1'b1;
        wait (pending_items.size() == 0);
        hold_sender = 1'b1;
        wait (expected_bytes.size() == 0);
        repeat (10) @(posedge clk);
        hold_sender = 1'b0;
      end
    end
    pending_items.push_back(make_item(OP_FLUSH, 0, COMP_Y));

    wait (pending_items.size() == 0 && !in_ch.valid);
    wait (expected_bytes.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("tb_jpeg_block_entropy_coder_top: done, clean");
    end else begin
      $display("tb_jpeg_block_entropy_coder_top: done, errors");
    end
    $finish;
  end

endmodule
